/* src/eurf_pkg.sv */
// ----------------------------------------------------------------------------
// eurf_pkg
// Shared widths, constants and types of the encoder unwrap and rate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package eurf_pkg;

    localparam int RAW_W          = 13;
    localparam int RATE_W         = 14;
    localparam int TURN_W         = 24;
    localparam int POS_W          = 37;
    localparam int ANG_W          = 48;
    localparam int WRAP_LIMIT     = 7500;
    localparam int DEG_PER_TURN   = 360;
    localparam int RING_DEPTH_DEF = 8;

    localparam logic signed [RATE_W-1:0] WRAP_HI   = RATE_W'(WRAP_LIMIT);
    localparam logic signed [RATE_W-1:0] WRAP_LO   = RATE_W'(-WRAP_LIMIT);
    // 8192 is the same bit pattern as -8192 at the rate width
    localparam logic signed [RATE_W-1:0] TURN_STEP = RATE_W'(1 << RAW_W);

    typedef struct packed {
        logic [RAW_W-1:0]         raw;
        logic signed [TURN_W-1:0] rounds;
        logic signed [RATE_W-1:0] rate;
    } eurf_item_t;

    typedef struct packed {
        logic accept;
        logic s1_go;
    } eurf_ctl_t;

endpackage

`default_nettype wire

/* src/eurf_ram.sv */
// ----------------------------------------------------------------------------
// eurf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module eurf_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/eurf_unwrap.sv */
// ----------------------------------------------------------------------------
// eurf_unwrap
// Turn unwrapping against the previous reading; loads the first stage.
// ----------------------------------------------------------------------------
`default_nettype none

module eurf_unwrap
    import eurf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [RAW_W-1:0] raw_position,
    output eurf_item_t            item
);

    logic [RAW_W-1:0]         prev_reg;
    logic signed [TURN_W-1:0] rounds_reg;
    logic signed [TURN_W-1:0] rounds_next;
    logic signed [RATE_W-1:0] diff;
    logic signed [RATE_W-1:0] rate_next;
    eurf_item_t               item_reg;

    always_comb
    begin
        diff = {1'b0, raw_position} - {1'b0, prev_reg};
        if (diff < WRAP_LO)
        begin
            rounds_next = rounds_reg + TURN_W'(1);
            rate_next   = diff + TURN_STEP;
        end
        else if (diff > WRAP_HI)
        begin
            rounds_next = rounds_reg - TURN_W'(1);
            rate_next   = diff - TURN_STEP;
        end
        else
        begin
            rounds_next = rounds_reg;
            rate_next   = diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            rounds_reg <= '0;
        end
        else if (accept)
        begin
            prev_reg   <= raw_position;
            rounds_reg <= rounds_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.raw    <= raw_position;
            item_reg.rounds <= rounds_next;
            item_reg.rate   <= rate_next;
        end
    end

    assign item = item_reg;

endmodule

`default_nettype wire

/* src/eurf_ring.sv */
// ----------------------------------------------------------------------------
// eurf_ring
// Rate ring in RAM: read the overwritten entry, update the running sum,
// write the new rate back.
// ----------------------------------------------------------------------------
`default_nettype none

module eurf_ring
    import eurf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire eurf_ctl_t                                  ctl,
    input  wire logic signed [RATE_W-1:0]                   s1_rate,
    output logic signed [RATE_W+$clog2(RING_DEPTH)-1:0]     sum
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W = RATE_W + $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic signed [SUM_W-1:0] SUM_BOUND =
        SUM_W'(RING_DEPTH * ((1 << RAW_W) - 1));

    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic [RING_DEPTH-1:0]    vld_reg;
    logic                     vld_old_reg;
    logic                     fwd_reg;
    logic signed [RATE_W-1:0] fwd_data_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic [RATE_W-1:0]        rd_data;
    logic signed [RATE_W-1:0] old_rate;

    eurf_ram #(
        .WIDTH (RATE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.s1_go),
        .wr_addr (s1_idx_reg),
        .wr_data (s1_rate),
        .rd_en   (ctl.accept),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (fwd_reg)
        begin
            old_rate = fwd_data_reg;
        end
        else if (vld_old_reg)
        begin
            old_rate = $signed(rd_data);
        end
        else
        begin
            old_rate = '0;
        end
        sum_next = sum_reg - SUM_W'(old_rate) + SUM_W'(s1_rate);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            vld_reg <= '0;
            fwd_reg <= 1'b0;
            sum_reg <= '0;
        end
        else
        begin
            if (ctl.accept)
            begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
                // write of the same entry in this cycle: take its data
                fwd_reg <= ctl.s1_go && (s1_idx_reg == idx_reg);
            end
            if (ctl.s1_go)
            begin
                vld_reg[s1_idx_reg] <= 1'b1;
                sum_reg             <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            s1_idx_reg   <= idx_reg;
            vld_old_reg  <= vld_reg[idx_reg];
            fwd_data_reg <= s1_rate;
        end
    end

    assign sum = sum_reg;

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.s1_go |=> vld_reg[$past(s1_idx_reg)])
        else $error("ring entry not marked valid after write");

    a_read_index: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> (s1_idx_reg == $past(idx_reg)))
        else $error("ring read index not carried into stage");

    a_fwd_depth: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> (RING_DEPTH == 1))
        else $error("same-entry forward with distinct consecutive entries");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg <= SUM_BOUND) && (sum_reg >= -SUM_BOUND))
        else $error("ring sum out of range");

endmodule

`default_nettype wire

/* src/encoder_unwrap_rate_filter.sv */
// ----------------------------------------------------------------------------
// encoder_unwrap_rate_filter
// Multi-turn encoder unwrap with angle output and moving-average rate.
//
//   channel   | handshake                 | beat
//   ----------+---------------------------+-------------------------------
//   sample    | sample_valid/sample_stall | raw_position
//   result    | result_valid/result_stall | continuous_position, angle_q13,
//             |                           | step_rate, filtered_rate,
//             |                           | turn_count
//   cfg       | cfg_valid/cfg_ready       | angle_bias
//
// One beat per cycle sustained while result_stall is low; a sample passes stage 1, stage 2 and the output register.
// Stage 1 waits on the ring RAM read, stage 2 holds the updated sum, the
// output register divides the sum and scales the angle.
// Reset clears the turn state, ring valid bits and sum; no clearing pass.
// A stalled result is held while two more samples can still enter.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_unwrap_rate_filter
    import eurf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     sample_valid,
    output logic                          sample_stall,
    input  wire logic [RAW_W-1:0]         raw_position,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic signed [POS_W-1:0]       continuous_position,
    output logic signed [ANG_W-1:0]       angle_q13,
    output logic signed [RATE_W-1:0]      step_rate,
    output logic signed [RATE_W-1:0]      filtered_rate,
    output logic signed [TURN_W-1:0]      turn_count,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [RAW_W-1:0]         angle_bias
);

    localparam int CLOG        = $clog2(RING_DEPTH);
    localparam int SUM_W       = RATE_W + CLOG;
    localparam int MAG_W       = SUM_W - 1;
    localparam int RECIP_SHIFT = MAG_W + CLOG;
    localparam int RECIP_W     = MAG_W + 2;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam longint RECIP   =
        ((longint'(1) << RECIP_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic                     out_valid_reg;
    logic                     out_free;
    logic                     s2_free;
    logic                     s1_free;
    logic                     s2_go;
    eurf_ctl_t                ctl;
    eurf_item_t               s1_item;
    logic signed [SUM_W-1:0]  sum;
    logic [RAW_W-1:0]         bias_reg;

    logic signed [POS_W-1:0]  s2_pos_reg;
    logic signed [POS_W:0]    s2_dbias_reg;
    logic signed [RATE_W-1:0] s2_rate_reg;
    logic signed [TURN_W-1:0] s2_turns_reg;
    logic signed [POS_W-1:0]  pos;

    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic [RAW_W-1:0]         quot;
    logic signed [RATE_W-1:0] filt;
    logic signed [ANG_W-1:0]  ang;

    logic signed [POS_W-1:0]  pos_out_reg;
    logic signed [ANG_W-1:0]  ang_out_reg;
    logic signed [RATE_W-1:0] rate_out_reg;
    logic signed [RATE_W-1:0] filt_out_reg;
    logic signed [TURN_W-1:0] turns_out_reg;

    assign out_free     = !out_valid_reg || !result_stall;
    assign s2_go        = s2_valid_reg && out_free;
    assign s2_free      = !s2_valid_reg || out_free;
    assign ctl.s1_go    = s1_valid_reg && s2_free;
    assign s1_free      = !s1_valid_reg || s2_free;
    assign sample_stall = !s1_free;
    assign ctl.accept   = sample_valid && s1_free;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bias_reg      <= '0;
        end
        else
        begin
            if (ctl.accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (ctl.s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (ctl.s1_go)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                bias_reg <= angle_bias;
            end
        end
    end

    eurf_unwrap u_unwrap (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (ctl.accept),
        .raw_position (raw_position),
        .item         (s1_item)
    );

    eurf_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .s1_rate (s1_item.rate),
        .sum     (sum)
    );

    assign pos = {s1_item.rounds, s1_item.raw};

    always_ff @(posedge clk)
    begin
        if (ctl.s1_go)
        begin
            s2_pos_reg   <= pos;
            s2_dbias_reg <= {pos[POS_W-1], pos} - (POS_W + 1)'(bias_reg);
            s2_rate_reg  <= s1_item.rate;
            s2_turns_reg <= s1_item.rounds;
        end
    end

    // divide by the ring depth: reciprocal multiply on the magnitude
    always_comb
    begin
        mag  = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
        prod = PROD_W'(mag) * PROD_W'(RECIP_C);
        quot = prod[RECIP_SHIFT +: RAW_W];
        filt = sum[SUM_W-1] ? -RATE_W'(quot) : RATE_W'(quot);
        ang  = ANG_W'(s2_dbias_reg) * ANG_W'(DEG_PER_TURN);
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            pos_out_reg   <= s2_pos_reg;
            ang_out_reg   <= ang;
            rate_out_reg  <= s2_rate_reg;
            filt_out_reg  <= filt;
            turns_out_reg <= s2_turns_reg;
        end
    end

    assign result_valid        = out_valid_reg;
    assign continuous_position = pos_out_reg;
    assign angle_q13           = ang_out_reg;
    assign step_rate           = rate_out_reg;
    assign filtered_rate       = filt_out_reg;
    assign turn_count          = turns_out_reg;

endmodule

`default_nettype wire
